@@ hdl/dconv_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the direct 2-d convolution block
// no dependencies

package dconv_pkg;

    // store geometry
    localparam int MAX_SIZE    = 64;
    localparam int MAX_KERNEL  = 7;
    localparam int IMG_AW      = 2 * $clog2(MAX_SIZE);
    localparam int IMG_DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int KER_DEPTH   = MAX_KERNEL * MAX_KERNEL;
    localparam int KER_AW      = $clog2(KER_DEPTH);
    localparam int POS_W       = $clog2(MAX_SIZE);
    localparam int TAP_W       = $clog2(MAX_KERNEL + 1);

    // data widths
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = 37;
    localparam int SUM_W       = 48;
    localparam int TOTAL_W     = SUM_W + 1;

    // configuration fields
    localparam int SIZE_W      = 7;
    localparam int RAD_W       = 2;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // item kinds
    localparam logic [1:0] KIND_KERNEL = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_IMAGE_SIZE    = 2'd0;
    localparam logic [1:0] REG_KERNEL_RADIUS = 2'd1;
    localparam logic [1:0] REG_ADDITIVE_MODE = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST    = SIZE_W'(64);
    localparam logic [RAD_W-1:0]  KERNEL_RADIUS_RST = RAD_W'(1);

    // largest radius whose side still fits the kernel store
    localparam int RAD_FIT = (MAX_KERNEL - 1) / 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

endpackage

@@ hdl/direct_2d_convolution.sv @@
`timescale 1ns / 1ps
// direct 2-d convolution (same-size, zero-padded cross-correlation) engine
// depends on dconv_pkg

// Command-style engine holding a square kernel (up to 7x7) and a square
// image (up to 64x64) of signed Q8.8 values. Each transfer on the start
// port is one item: kind 0 loads a kernel coefficient, kind 1 loads an
// image pixel, kind 2 queries one output position, kind 3 does nothing.
// Loads are taken without raising busy. A query whose row
// or col lies outside the image in use gives no result and also leaves
// busy low. A query inside the image runs one shared 16x16 multiplier
// and accumulator over the (2s+1)^2 taps of the window, one tap a cycle,
// holding busy high through the run state, then a drain state that lets
// the memory read and multiply stages empty, then a done state for the
// prior add and saturation. The result appears on o_sum / o_saturated
// for exactly one cycle with o_valid high, in the first cycle that busy
// is low again; the receiver cannot stall it, and a new item may be
// started in that same cycle. Taps falling outside the image count as
// zero. Sums are Q32.16, saturated to 48 bits with o_saturated flagging
// a clip. Image and kernel entries must be written before a query reads
// them; the stores are not cleared at reset. Configuration goes through
// the APB port: image_size at 0x0, kernel_radius at 0x4, additive_mode
// at 0x8; write only while idle.

module direct_2d_convolution
    import dconv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // apb configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,

    // command side
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_kind,
    input  logic [POS_W-1:0]    i_row,
    input  logic [POS_W-1:0]    i_col,
    input  t_sample             i_sample,
    input  t_sum                i_prior,

    // result side
    output logic                o_valid,
    output t_sum                o_sum,
    output logic                o_saturated
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] r_image_size;
    logic [RAD_W-1:0]  r_kernel_radius;
    logic              r_additive_mode;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= IMAGE_SIZE_RST;
            r_kernel_radius <= KERNEL_RADIUS_RST;
            r_additive_mode <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_IMAGE_SIZE:    r_image_size    <= pwdata[SIZE_W-1:0];
                REG_KERNEL_RADIUS: r_kernel_radius <= pwdata[RAD_W-1:0];
                REG_ADDITIVE_MODE: r_additive_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_IMAGE_SIZE:    prdata = APB_DW'(r_image_size);
            REG_KERNEL_RADIUS: prdata = APB_DW'(r_kernel_radius);
            REG_ADDITIVE_MODE: prdata = APB_DW'(r_additive_mode);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // effective sizes: image side clamps to the store, radius to the kernel
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_eff;
    logic [RAD_W-1:0]  rad_eff;

    assign size_eff = (r_image_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : r_image_size;
    assign rad_eff  = ({1'b0, r_kernel_radius, 1'b1} > (RAD_W + 2)'(MAX_KERNEL))
                    ? RAD_W'(RAD_FIT) : r_kernel_radius;

    // ------------------------------------------------------------------
    // command accept and decode
    // ------------------------------------------------------------------
    logic       accept;
    logic       query_ok;
    logic [1:0] r_state;
    logic [1:0] n_state;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // a query outside the image in use (or zero-size image) yields nothing
    assign query_ok = (i_kind == KIND_QUERY)
                   && ({1'b0, i_row} < size_eff)
                   && ({1'b0, i_col} < size_eff);

    // ------------------------------------------------------------------
    // stores: written on a load transfer, read one tap a cycle
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] img_mem [IMG_DEPTH];
    logic [SAMPLE_W-1:0] ker_mem [KER_DEPTH];
    logic [IMG_AW-1:0]   img_waddr;
    logic [KER_AW-1:0]   ker_waddr;
    logic                img_we;
    logic                ker_we;
    logic [IMG_AW-1:0]   img_raddr;
    logic [KER_AW-1:0]   ker_raddr;
    logic [SAMPLE_W-1:0] r_img_q;
    logic [SAMPLE_W-1:0] r_ker_q;

    // pixel loads cover the whole 64x64 store; coefficient loads with row or col of 7 or more drop
    assign img_we    = accept && (i_kind == KIND_PIXEL);
    assign ker_we    = accept && (i_kind == KIND_KERNEL)
                    && (i_row < POS_W'(MAX_KERNEL)) && (i_col < POS_W'(MAX_KERNEL));
    assign img_waddr = {i_row, i_col};
    assign ker_waddr = KER_AW'(i_row) * KER_AW'(MAX_KERNEL) + KER_AW'(i_col);

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            img_mem[img_waddr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ker_we) begin
            ker_mem[ker_waddr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_img_q <= img_mem[img_raddr];
        r_ker_q <= ker_mem[ker_raddr];
    end

    // ------------------------------------------------------------------
    // query context, latched at the accepting edge
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [RAD_W-1:0]  r_rad;
    logic [SIZE_W-1:0] r_size;
    t_sum              r_prior;

    always_ff @(posedge i_clk) begin
        if (accept && query_ok) begin
            r_row   <= i_row;
            r_col   <= i_col;
            r_rad   <= rad_eff;
            r_size  <= size_eff;
            r_prior <= r_additive_mode ? i_prior : '0;
        end
    end

    // ------------------------------------------------------------------
    // tap sequencer: window row ki and column kj, 0 .. 2s
    // ------------------------------------------------------------------
    logic [TAP_W-1:0]    r_ki;
    logic [TAP_W-1:0]    r_kj;
    logic [TAP_W-1:0]    side_m1;
    logic                last_col;
    logic                last_tap;
    logic signed [POS_W+1:0] tap_a;
    logic signed [POS_W+1:0] tap_b;
    logic                a_ok;
    logic                b_ok;
    logic                tap_ok;
    logic                r_drain;

    assign side_m1  = TAP_W'({r_rad, 1'b0});
    assign last_col = (r_kj == side_m1);
    assign last_tap = last_col && (r_ki == side_m1);

    // image coordinates of this tap; negative or past the side means zero pad
    assign tap_a = $signed({2'b00, r_row}) + $signed((POS_W + 2)'(r_ki))
                 - $signed((POS_W + 2)'(r_rad));
    assign tap_b = $signed({2'b00, r_col}) + $signed((POS_W + 2)'(r_kj))
                 - $signed((POS_W + 2)'(r_rad));
    assign a_ok   = !tap_a[POS_W+1] && ((SIZE_W)'(tap_a[POS_W:0]) < r_size);
    assign b_ok   = !tap_b[POS_W+1] && ((SIZE_W)'(tap_b[POS_W:0]) < r_size);
    assign tap_ok = a_ok && b_ok;

    assign img_raddr = {tap_a[POS_W-1:0], tap_b[POS_W-1:0]};
    assign ker_raddr = KER_AW'(r_ki) * KER_AW'(MAX_KERNEL) + KER_AW'(r_kj);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && query_ok) n_state = ST_RUN;
            ST_RUN:   if (last_tap) n_state = ST_DRAIN;
            ST_DRAIN: if (r_drain) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ki    <= '0;
            r_kj    <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_ki <= '0;
                r_kj <= '0;
            end else if (r_state == ST_RUN) begin
                if (last_col) begin
                    r_kj <= '0;
                    r_ki <= r_ki + 1'b1;
                end else begin
                    r_kj <= r_kj + 1'b1;
                end
            end
            // the drain state lets the read and multiply stages empty
            r_drain <= (r_state == ST_DRAIN) && !r_drain;
        end
    end

    // ------------------------------------------------------------------
    // shared multiply-accumulate: read -> product -> accumulate
    // ------------------------------------------------------------------
    logic                      r_rd_vld;
    logic                      r_prod_vld;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= (r_state == ST_RUN) && tap_ok;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_img_q) * $signed(r_ker_q);
        if (accept && query_ok) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // ------------------------------------------------------------------
    // prior add, saturation to 48 bits and result register
    // ------------------------------------------------------------------
    logic signed [TOTAL_W-1:0] total;
    logic                      ovf;

    assign total = TOTAL_W'(r_acc) + TOTAL_W'(r_prior);
    assign ovf   = total[TOTAL_W-1] != total[TOTAL_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_saturated <= ovf;
            if (ovf) begin
                // clip toward the sign of the true total
                o_sum <= {total[TOTAL_W-1], {(SUM_W-1){!total[TOTAL_W-1]}}};
            end else begin
                o_sum <= total[SUM_W-1:0];
            end
        end
    end

endmodule

@@ sim/direct_2d_convolution_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the direct 2-d convolution engine
// depends on dconv_pkg and direct_2d_convolution

module direct_2d_convolution_tb;
    import dconv_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int QUIET_CYCLES = MAX_KERNEL * MAX_KERNEL + 3 + 8;

    // kind 3 carries no operation; index 3 is past the register file
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam t_sample S_MAX = 16'sh7FFF;
    localparam t_sample S_MIN = 16'sh8000;

    typedef struct {
        t_sum total;
        logic clipped;
    } t_sum_rec;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [1:0]          i_kind;
    logic [POS_W-1:0]    i_row;
    logic [POS_W-1:0]    i_col;
    t_sample             i_sample;
    t_sum                i_prior;
    logic                o_valid;
    t_sum                o_sum;
    logic                o_saturated;

    direct_2d_convolution dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_sample    (i_sample),
        .i_prior     (i_prior),
        .o_valid     (o_valid),
        .o_sum       (o_sum),
        .o_saturated (o_saturated)
    );

    // shadow copy of the engine: register file and both stores
    logic [SIZE_W-1:0] cfg_size;
    logic [RAD_W-1:0]  cfg_radius;
    logic              cfg_additive;
    t_sample           pixel_mem [IMG_DEPTH];
    bit                pixel_set [IMG_DEPTH];
    t_sample           coef_mem  [KER_DEPTH];
    bit                coef_set  [KER_DEPTH];

    // correlation sums still owed by the engine, oldest first
    t_sum_rec pending_sums [$];
    t_sum_rec head;

    bit burst_mode;
    int items_sent, work_items, queries_sent, loads_sent;
    int results_seen, clipped_seen, settings_used, mismatches;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    endfunction

    function automatic int eff_size();
        return (cfg_size > MAX_SIZE) ? MAX_SIZE : int'(cfg_size);
    endfunction

    function automatic int eff_radius();
        int s;
        s = cfg_radius;
        if (2 * s + 1 > MAX_KERNEL)
            s = RAD_FIT;
        return s;
    endfunction

    // window sum around (r, c), clipped to the image, saturated to 48 bits
    function automatic bit correlate_at(input int r, input int c, input t_sum prior,
                                        output t_sum_rec rec);
        int n, s;
        longint acc;
        n = eff_size();
        s = eff_radius();
        acc = 0;
        rec.total = '0;
        rec.clipped = 1'b0;
        if (r >= n || c >= n)
            return 1'b0;
        for (int di = -s; di <= s; di++) begin
            if (r + di < 0 || r + di >= n)
                continue;
            for (int dj = -s; dj <= s; dj++) begin
                if (c + dj < 0 || c + dj >= n)
                    continue;
                acc += longint'(pixel_mem[(r + di) * MAX_SIZE + c + dj])
                     * longint'(coef_mem[(di + s) * MAX_KERNEL + dj + s]);
            end
        end
        if (cfg_additive)
            acc += longint'(prior);
        if (acc > SUM_HI) begin
            acc = SUM_HI;
            rec.clipped = 1'b1;
        end else if (acc < SUM_LO) begin
            acc = SUM_LO;
            rec.clipped = 1'b1;
        end
        rec.total = t_sum'(acc);
        return 1'b1;
    endfunction

    function automatic logic [APB_DW-1:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_IMAGE_SIZE:    return APB_DW'(cfg_size);
            REG_KERNEL_RADIUS: return APB_DW'(cfg_radius);
            REG_ADDITIVE_MODE: return APB_DW'(cfg_additive);
            default:           return '0;
        endcase
    endfunction

    function automatic t_sum rand_prior();
        longint margin;
        margin = longint'($urandom_range(0, 32'h3FFF_FFFF));
        case ($urandom_range(0, 3))
            0:       return t_sum'(SUM_HI - margin);
            1:       return t_sum'(SUM_LO + margin);
            default: return t_sum'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic t_sample rand_sample();
        return t_sample'($urandom());
    endfunction

    // apb write: setup cycle, then access until pready
    task automatic write_register(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_SIZE:    cfg_size     = data[SIZE_W-1:0];
            REG_KERNEL_RADIUS: cfg_radius   = data[RAD_W-1:0];
            REG_ADDITIVE_MODE: cfg_additive = data[0];
            default: ;
        endcase
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [APB_DW-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== register_value(idx))
            report_mismatch($sformatf("register %0d read", idx),
                            64'(register_value(idx)), 64'(got));
    endtask

    // one transfer on the command side; start stays high when the next item follows at once
    task automatic send_item(input logic [1:0] kind, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col, input t_sample sample,
                             input t_sum prior);
        int gap;
        t_sum_rec rec;
        if ($urandom_range(0, 59) == 0)
            burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_kind   <= kind;
        i_row    <= row;
        i_col    <= col;
        i_sample <= sample;
        i_prior  <= prior;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        case (kind)
            KIND_KERNEL: begin
                loads_sent++;
                if (row < MAX_KERNEL && col < MAX_KERNEL) begin
                    coef_mem[row * MAX_KERNEL + col] = sample;
                    coef_set[row * MAX_KERNEL + col] = 1'b1;
                    work_items++;
                end
            end
            KIND_PIXEL: begin
                loads_sent++;
                work_items++;
                pixel_mem[row * MAX_SIZE + col] = sample;
                pixel_set[row * MAX_SIZE + col] = 1'b1;
            end
            KIND_QUERY: begin
                queries_sent++;
                work_items++;
                if (correlate_at(row, col, prior, rec))
                    pending_sums.push_back(rec);
            end
            default: ;
        endcase
    endtask

    // loads whatever taps and pixels the query window would read before they are written
    task automatic fill_window(input int r, input int c);
        int n, s;
        n = eff_size();
        s = eff_radius();
        for (int ki = 0; ki <= 2 * s; ki++)
            for (int kj = 0; kj <= 2 * s; kj++)
                if (!coef_set[ki * MAX_KERNEL + kj])
                    send_item(KIND_KERNEL, POS_W'(ki), POS_W'(kj), rand_sample(), rand_prior());
        for (int a = r - s; a <= r + s; a++)
            for (int b = c - s; b <= c + s; b++)
                if (a >= 0 && a < n && b >= 0 && b < n && !pixel_set[a * MAX_SIZE + b])
                    send_item(KIND_PIXEL, POS_W'(a), POS_W'(b), rand_sample(), rand_prior());
    endtask

    task automatic query_item(input int r, input int c, input t_sum prior);
        if (r < eff_size() && c < eff_size())
            fill_window(r, c);
        send_item(KIND_QUERY, POS_W'(r), POS_W'(c), '0, prior);
    endtask

    // drop start, let every owed result arrive, then give the engine time to go idle
    task automatic wait_until_quiet();
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // register writes carry junk above each field to show it is masked
    task automatic apply_setting(input int n, input int s, input bit add);
        wait_until_quiet();
        write_register(REG_IMAGE_SIZE, (APB_DW'($urandom()) << SIZE_W) | APB_DW'(n));
        write_register(REG_KERNEL_RADIUS, (APB_DW'($urandom()) << RAD_W) | APB_DW'(s));
        write_register(REG_ADDITIVE_MODE, (APB_DW'($urandom()) << 1) | APB_DW'(add));
        check_register(REG_IMAGE_SIZE);
        check_register(REG_KERNEL_RADIUS);
        check_register(REG_ADDITIVE_MODE);
        settings_used++;
    endtask

    function automatic int border_pos(input int n);
        return $urandom_range(0, 1) ? $urandom_range(0, 3) : n - 1 - $urandom_range(0, 3);
    endfunction

    task automatic run_random_mix(input int budget);
        int stop_at, pick, n, r, c;
        stop_at = work_items + budget;
        while (work_items < stop_at) begin
            n = eff_size();
            pick = $urandom_range(0, 99);
            if (pick < 55 && n > 0) begin
                // large images stay near the borders so few pixels need loading
                if (n > 16 && $urandom_range(0, 4) != 0) begin
                    r = border_pos(n);
                    c = border_pos(n);
                end else begin
                    r = $urandom_range(0, n - 1);
                    c = $urandom_range(0, n - 1);
                end
                query_item(r, c, rand_prior());
            end else if (pick < 65) begin
                query_item($urandom_range(0, 63), $urandom_range(0, 63), rand_prior());
            end else if (pick < 85) begin
                send_item(KIND_PIXEL, POS_W'($urandom()), POS_W'($urandom()),
                          rand_sample(), rand_prior());
            end else if (pick < 93) begin
                r = $urandom_range(0, 3) != 0 ? $urandom_range(0, 6) : $urandom_range(0, 63);
                c = $urandom_range(0, 3) != 0 ? $urandom_range(0, 6) : $urandom_range(0, 63);
                send_item(KIND_KERNEL, POS_W'(r), POS_W'(c), rand_sample(), rand_prior());
            end else begin
                send_item(KIND_NONE, POS_W'($urandom()), POS_W'($urandom()),
                          rand_sample(), rand_prior());
            end
        end
    endtask

    // reset values, masking of wide writes, and a write to the unused index
    task automatic test_register_access();
        check_register(REG_IMAGE_SIZE);
        check_register(REG_KERNEL_RADIUS);
        check_register(REG_ADDITIVE_MODE);
        write_register(REG_IMAGE_SIZE, 32'hFFFF_FF80 | APB_DW'(5));
        write_register(REG_KERNEL_RADIUS, 32'hFFFF_FFFE);
        write_register(REG_ADDITIVE_MODE, 32'hFFFF_FFFF);
        write_register(REG_UNUSED, 32'h0000_0000);
        check_register(REG_IMAGE_SIZE);
        check_register(REG_KERNEL_RADIUS);
        check_register(REG_ADDITIVE_MODE);
    endtask

    // sample and image size extremes, all kinds, dropped loads, clipping, odd image sizes
    task automatic test_directed_cases();
        apply_setting(2, 0, 1'b0);
        send_item(KIND_KERNEL, POS_W'(0), POS_W'(0), S_MIN, '0);
        send_item(KIND_KERNEL, POS_W'(7), POS_W'(3), 16'sh1234, '0);  // past the store, dropped
        send_item(KIND_KERNEL, POS_W'(6), POS_W'(6), S_MAX, '0);  // kept though never read
        send_item(KIND_PIXEL, POS_W'(0), POS_W'(0), S_MIN, '0);
        send_item(KIND_PIXEL, POS_W'(0), POS_W'(1), S_MAX, '0);
        send_item(KIND_PIXEL, POS_W'(1), POS_W'(0), 16'sd1, '0);
        send_item(KIND_PIXEL, POS_W'(1), POS_W'(1), -16'sd1, '0);
        send_item(KIND_PIXEL, POS_W'(63), POS_W'(63), S_MAX, '0); // outside the image, kept
        send_item(KIND_NONE, POS_W'(63), POS_W'(63), S_MAX, t_sum'(SUM_HI));
        query_item(0, 0, t_sum'(SUM_HI));               // prior ignored when not additive
        query_item(1, 1, '0);
        query_item(2, 0, '0);                           // row past the image, no result
        query_item(0, 63, '0);
        // additive mode pushed into both clip limits
        apply_setting(2, 0, 1'b1);
        query_item(0, 0, t_sum'(SUM_HI));
        query_item(0, 1, t_sum'(SUM_LO));
        query_item(1, 0, -48'sd1);
        // zero size makes every query out of range
        apply_setting(0, 0, 1'b1);
        query_item(0, 0, '0);
        // an oversized image acts as the full store
        apply_setting(127, 0, 1'b1);
        query_item(63, 63, '0);
    endtask

    task automatic test_random_settings();
        apply_setting(1, 0, 1'b0);
        run_random_mix(60);
        apply_setting(64, 3, 1'b1);
        run_random_mix(150);
        apply_setting(3, 3, 1'b0);
        run_random_mix(90);
        apply_setting(127, 2, 1'b1);
        run_random_mix(120);
        apply_setting(0, 1, 1'b1);
        run_random_mix(25);
        apply_setting(8, 1, 1'b0);
        run_random_mix(90);
        for (int k = 0; k < 6; k++) begin
            apply_setting($urandom_range(1, 16), $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            run_random_mix(95);
        end
    endtask

    // every strobed result is compared with the oldest owed sum
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_sums.size() == 0) begin
                report_mismatch("result with nothing owed", '0, 64'(o_sum));
            end else begin
                head = pending_sums.pop_front();
                if (head.clipped)
                    clipped_seen++;
                if (o_sum !== head.total)
                    report_mismatch("sum", 64'(head.total), 64'(o_sum));
                if (o_saturated !== head.clipped)
                    report_mismatch("saturated flag", 64'(head.clipped), 64'(o_saturated));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d results still owed", pending_sums.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_kind       = KIND_NONE;
        i_row        = '0;
        i_col        = '0;
        i_sample     = '0;
        i_prior      = '0;
        cfg_size     = IMAGE_SIZE_RST;
        cfg_radius   = KERNEL_RADIUS_RST;
        cfg_additive = 1'b0;
        burst_mode   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_directed_cases();
        test_random_settings();
        wait_until_quiet();

        $display("sent %0d transfers (%0d queries, %0d loads) over %0d register settings",
                 items_sent, queries_sent, loads_sent, settings_used);
        $display("checked %0d results, %0d clipped, %0d mismatches",
                 results_seen, clipped_seen, mismatches);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
